### design/ddh_pkg.sv
// Shared types and constants for the dihedral deletion deck hash.
package ddh_pkg;
   localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
   localparam logic [63:0] HASH_PRIME = 64'd1099511628211;
   localparam int unsigned PRIME_SHIFT = 40;
   localparam logic [8:0] PRIME_LOW = 9'd435;
   localparam int unsigned HIGH_SHIFT = 16;
   localparam logic [5:0] MIN_DECK_CARD = 6'd3;
   localparam logic [5:0] MIN_RING = 6'd3;
   localparam logic [5:0] RESET_MODULUS = 6'd12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CANON,
      ST_DECK_CANON,
      ST_INSERT,
      ST_HASH_MULTI,
      ST_DEDUP,
      ST_HASH_SET,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic canon_start;
      logic canon_deck;
      logic next_member;
      logic insert_key;
      logic hash_start;
      logic hash_step;
      logic hash_set;
      logic dedup_step;
   } cmd_type;

   typedef struct packed {
      logic canon_done;
      logic deck_valid;
      logic members_left;
      logic insert_done;
      logic hash_done;
      logic dedup_done;
   } stat_type;

   typedef struct packed {
      logic [31:0] canonical_form;
      logic        is_representative;
      logic [5:0]  cardinality;
      logic        deck_valid;
      logic [63:0] multiset_hash;
      logic [5:0]  distinct_count;
      logic [63:0] set_hash;
   } rsp_type;
endpackage

### design/ddh_req_if.sv
// Request and response channel interfaces.
interface ddh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] mask;
   modport source (output valid, output mask, input ready);
   modport sink (input valid, input mask, output ready);
endinterface

interface ddh_rsp_if import ddh_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/dihedral_deletion_deck_hash.sv
// Top level of the dihedral deletion deck hash.
// channel | direction | payload
// req     | in        | mask[31:0]
// rsp     | out       | canonical form, flags, count, two 64-bit hashes
// csr     | in        | modulus_n[5:0]
// One item at a time. The canonical form comes first; if the deck is valid, each
// deletion is canonicalised and insertion-sorted into the key store, then the keys
// are hashed, de-duplicated and hashed again as a set.
// Reset is synchronous and sets modulus_n to 12; a held response stalls intake.
module dihedral_deletion_deck_hash import ddh_pkg::*; #(
   parameter int MAX_MODULUS = 32
) (
   input  logic          clock,
   input  logic          reset,
   ddh_req_if.sink       req,
   ddh_rsp_if.source     rsp,
   input  logic          csr_write,
   input  logic [5:0]    csr_wdata
);
   logic [5:0] modulus_ff;
   cmd_type    cmd;
   stat_type   stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= RESET_MODULUS;
      end else if (csr_write) begin
         modulus_ff <= csr_wdata;
      end
   end

   ddh_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   ddh_datapath #(.MAX_MODULUS(MAX_MODULUS)) u_dp (
      .clock(clock), .reset(reset), .modulus(modulus_ff), .mask_in(req.mask),
      .cmd(cmd), .stat(stat), .rsp(rsp.data)
   );
endmodule

### design/ddh_ctrl.sv
// Sequencing state machine.
module ddh_ctrl import ddh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   input  stat_type  stat,
   output cmd_type   cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CANON;
         end
         ST_CANON: begin
            if (stat.canon_done) begin
               if (stat.deck_valid) state_in = ST_DECK_CANON;
               else state_in = ST_DONE;
            end
         end
         ST_DECK_CANON: begin
            if (stat.canon_done) state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (stat.insert_done) begin
               if (stat.members_left) state_in = ST_DECK_CANON;
               else state_in = ST_HASH_MULTI;
            end
         end
         ST_HASH_MULTI: begin
            if (stat.hash_done) state_in = ST_DEDUP;
         end
         ST_DEDUP: begin
            if (stat.dedup_done) state_in = ST_HASH_SET;
         end
         ST_HASH_SET: begin
            if (stat.hash_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
            cmd.canon_start = req_valid;
         end
         ST_CANON: begin
            if (stat.canon_done && stat.deck_valid) begin
               cmd.canon_start = 1'b1;
               cmd.canon_deck = 1'b1;
            end
         end
         ST_DECK_CANON: begin
            if (stat.canon_done) cmd.next_member = 1'b1;
         end
         ST_INSERT: begin
            cmd.insert_key = 1'b1;
            if (stat.insert_done) begin
               if (stat.members_left) begin
                  cmd.canon_start = 1'b1;
                  cmd.canon_deck = 1'b1;
               end else begin
                  cmd.hash_start = 1'b1;
               end
            end
         end
         ST_HASH_MULTI: begin
            cmd.hash_step = 1'b1;
         end
         ST_DEDUP: begin
            cmd.dedup_step = 1'b1;
            if (stat.dedup_done) cmd.hash_start = 1'b1;
         end
         ST_HASH_SET: begin
            cmd.hash_step = 1'b1;
            cmd.hash_set = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: cmd = '0;
      endcase
   end
endmodule

### design/ddh_datapath.sv
// Canonicaliser, key store, sorter and hash datapath.
module ddh_datapath import ddh_pkg::*; #(
   parameter int MAX_MODULUS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [5:0]  modulus,
   input  logic [31:0] mask_in,
   input  cmd_type     cmd,
   output stat_type    stat,
   output rsp_type     rsp
);
   localparam int KW = $clog2(MAX_MODULUS + 1);
   localparam int IW = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;

   logic [5:0]  n_ff;
   logic [31:0] full_ff, mask_ff, best_ff, rot_ff, base_ff;
   logic [5:0]  rot_cnt_ff;
   logic        phase_ff, canon_busy_ff;
   logic [5:0]  card_ff;
   logic [5:0]  member_ff;
   logic [31:0] keys_ff [MAX_MODULUS];
   logic [KW-1:0] len_ff, ins_ff, dist_ff, rd_ff;
   logic        ins_busy_ff;
   logic [31:0] key_ff;
   logic [63:0] hash_ff, mhash_ff, shash_ff;
   logic [KW-1:0] hidx_ff;
   logic        hhalf_ff, hmul_ff;
   logic [63:0] hx_ff;
   logic        deck_valid_ff;

   logic [5:0]  n_eff;
   logic [31:0] full_eff, masked, rot_next, refl_val;
   logic [5:0]  card_cnt;

   always_comb begin
      n_eff = modulus;
      if (n_eff < MIN_RING) n_eff = MIN_RING;
      if (n_eff > 6'(MAX_MODULUS)) n_eff = 6'(MAX_MODULUS);
      full_eff = (n_eff >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n_eff) - 32'd1);
      masked = mask_in & full_eff;
      card_cnt = '0;
      for (int i = 0; i < 32; i++) card_cnt = card_cnt + 6'(masked[i]);
   end

   always_comb begin
      rot_next = ((rot_ff << 1) | (rot_ff >> (n_ff - 6'd1))) & full_ff;
      refl_val = '0;
      for (int i = 0; i < 32; i++) begin
         if (6'(i) < n_ff && base_ff[i]) begin
            refl_val[(i == 0) ? 0 : (n_ff - 6'(i))] = 1'b1;
         end
      end
   end

   logic [5:0] next_member;
   always_comb begin
      next_member = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (6'(i) > member_ff && mask_ff[i]) next_member = 6'(i);
      end
   end

   logic [5:0] first_member;
   always_comb begin
      first_member = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (mask_ff[i]) first_member = 6'(i);
      end
   end

   logic [4:0]  del_idx;
   logic [31:0] deck_src;
   assign del_idx = cmd.insert_key ? next_member[4:0] : first_member[4:0];
   assign deck_src = mask_ff & ~(32'd1 << del_idx);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= n_eff;
         full_ff <= full_eff;
         mask_ff <= masked;
         card_ff <= card_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canon_busy_ff <= 1'b0;
      end else if (cmd.canon_start) begin
         canon_busy_ff <= 1'b1;
      end else if (canon_busy_ff && phase_ff && rot_cnt_ff == n_ff) begin
         canon_busy_ff <= 1'b0;
      end
   end

   logic [31:0] start_val;
   assign start_val = cmd.canon_deck ? deck_src : masked;

   always_ff @(posedge clock) begin
      if (cmd.canon_start) begin
         base_ff <= start_val;
         rot_ff <= start_val;
         best_ff <= start_val;
         rot_cnt_ff <= '0;
         phase_ff <= 1'b0;
      end else if (canon_busy_ff) begin
         if (rot_cnt_ff == n_ff) begin
            if (!phase_ff) begin
               phase_ff <= 1'b1;
               rot_ff <= refl_val;
               rot_cnt_ff <= '0;
            end
         end else begin
            if (rot_ff < best_ff) best_ff <= rot_ff;
            rot_ff <= rot_next;
            rot_cnt_ff <= rot_cnt_ff + 6'd1;
         end
      end
   end

   logic canon_done;
   assign canon_done = canon_busy_ff && phase_ff && rot_cnt_ff == n_ff;

   logic first_canon_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         first_canon_ff <= 1'b0;
         deck_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         first_canon_ff <= 1'b1;
         deck_valid_ff <= 1'b0;
      end else if (canon_done && first_canon_ff) begin
         first_canon_ff <= 1'b0;
         deck_valid_ff <= (best_ff == mask_ff) && (card_ff >= MIN_DECK_CARD);
      end
   end

   logic [31:0] canon_hold_ff;
   always_ff @(posedge clock) begin
      if (canon_done && first_canon_ff) canon_hold_ff <= best_ff;
   end

   // insertion sort, one shift a cycle
   logic ins_done_w;
   assign ins_done_w = ins_busy_ff && (ins_ff == '0 || keys_ff[IW'(ins_ff - KW'(1))] <= key_ff);

   // member pointer: first member at deck start, next after each insert
   always_ff @(posedge clock) begin
      if (canon_done && first_canon_ff) begin
         member_ff <= first_member;
      end else if (cmd.insert_key && ins_done_w && !cmd.hash_start) begin
         member_ff <= next_member;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_busy_ff <= 1'b0;
      end else if (cmd.next_member) begin
         ins_busy_ff <= 1'b1;
      end else if (ins_done_w) begin
         ins_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff <= '0;
      end else if (cmd.next_member) begin
         key_ff <= best_ff;
         ins_ff <= len_ff;
      end else if (ins_busy_ff) begin
         if (ins_done_w) begin
            keys_ff[IW'(ins_ff)] <= key_ff;
            len_ff <= len_ff + KW'(1);
         end else begin
            keys_ff[IW'(ins_ff)] <= keys_ff[IW'(ins_ff - KW'(1))];
            ins_ff <= ins_ff - KW'(1);
         end
      end else if (cmd.dedup_step && rd_ff < len_ff) begin
         if (rd_ff == '0 || keys_ff[IW'(rd_ff)] != keys_ff[IW'(dist_ff - KW'(1))]) begin
            keys_ff[IW'(dist_ff)] <= keys_ff[IW'(rd_ff)];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_start && !cmd.dedup_step) begin
         rd_ff <= '0;
         dist_ff <= '0;
      end else if (cmd.dedup_step && rd_ff < len_ff) begin
         rd_ff <= rd_ff + KW'(1);
         if (rd_ff == '0 || keys_ff[IW'(rd_ff)] != keys_ff[IW'(dist_ff - KW'(1))]) begin
            dist_ff <= dist_ff + KW'(1);
         end
      end
   end

   // hash: xor then registered multiply, two rounds per key
   logic [KW-1:0] hlen;
   logic [31:0]   hkey;
   assign hlen = cmd.hash_set ? dist_ff : len_ff;
   assign hkey = keys_ff[IW'(hidx_ff)];

   always_ff @(posedge clock) begin
      if (cmd.hash_start) begin
         hash_ff <= HASH_BASIS;
         hidx_ff <= '0;
         hhalf_ff <= 1'b0;
         hmul_ff <= 1'b0;
      end else if (cmd.hash_step && hidx_ff < hlen) begin
         if (!hmul_ff) begin
            hx_ff <= hash_ff ^ {32'd0, hhalf_ff ? (hkey >> HIGH_SHIFT) : hkey};
            hmul_ff <= 1'b1;
         end else begin
            hash_ff <= (hx_ff << PRIME_SHIFT) + (hx_ff * PRIME_LOW);
            hmul_ff <= 1'b0;
            hhalf_ff <= !hhalf_ff;
            if (hhalf_ff) hidx_ff <= hidx_ff + KW'(1);
         end
      end
   end

   logic hash_done;
   assign hash_done = cmd.hash_step && hidx_ff == hlen;

   always_ff @(posedge clock) begin
      if (hash_done && !cmd.hash_set) mhash_ff <= (hash_ff == '0) ? 64'd1 : hash_ff;
      if (hash_done && cmd.hash_set) shash_ff <= (hash_ff == '0) ? 64'd1 : hash_ff;
   end

   always_comb begin
      stat.canon_done = canon_done;
      stat.deck_valid = (best_ff == mask_ff) && (card_ff >= MIN_DECK_CARD);
      stat.members_left = next_member != 6'd32;
      stat.insert_done = ins_done_w;
      stat.hash_done = hash_done;
      stat.dedup_done = cmd.dedup_step && rd_ff == len_ff;
      rsp.canonical_form = canon_hold_ff;
      rsp.is_representative = canon_hold_ff == mask_ff;
      rsp.cardinality = card_ff;
      rsp.deck_valid = deck_valid_ff;
      rsp.multiset_hash = deck_valid_ff ? mhash_ff : 64'd0;
      rsp.distinct_count = deck_valid_ff ? 6'(dist_ff) : 6'd0;
      rsp.set_hash = deck_valid_ff ? shash_ff : 64'd0;
   end
endmodule

### design/ddh_checker.sv
// Port-level checks for the deletion deck hash.
module ddh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_deck_valid,
   input logic rsp_is_rep,
   input logic [5:0] rsp_card,
   input logic [63:0] rsp_mhash
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("intake during response");
   a_deck: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deck_valid |-> rsp_is_rep && rsp_card >= 6'd3)
      else $error("deck flag wrong");
   a_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deck_valid |-> rsp_mhash == 64'd0) else $error("hash not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
endmodule

bind dihedral_deletion_deck_hash ddh_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_deck_valid(rsp.data.deck_valid), .rsp_is_rep(rsp.data.is_representative),
   .rsp_card(rsp.data.cardinality), .rsp_mhash(rsp.data.multiset_hash)
);
